// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files that check their own logic.
// Both macros sample on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge out of reset.
`define TGA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition never holds.
`define TGA_ASSERT_NEVER(lbl, cond, msg) \
    `TGA_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/tga_pkg.sv =====
`timescale 1ns / 1ps

package tga_pkg;

    // Default depth of the queue between the parser and the output stage.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_IDLE
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_BAD_KIND  = 2'd1,
        ST_BAD_DEPTH = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Header byte positions.
    localparam logic [4:0] HB_ID_LEN = 5'd0;
    localparam logic [4:0] HB_KIND   = 5'd2;
    localparam logic [4:0] HB_W_LO   = 5'd12;
    localparam logic [4:0] HB_W_HI   = 5'd13;
    localparam logic [4:0] HB_H_LO   = 5'd14;
    localparam logic [4:0] HB_H_HI   = 5'd15;
    localparam logic [4:0] HB_DEPTH  = 5'd16;
    localparam logic [4:0] HB_DESC   = 5'd17;

    // Supported image types and depths.
    localparam logic [7:0] KIND_RAW = 8'd2;
    localparam logic [7:0] KIND_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // Bit positions within header and packet bytes.
    localparam int RUN_BIT    = 7;
    localparam int ORIGIN_BIT = 5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // One decoded result word.
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_res;
        logic        is_last;
        t_status     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        top_origin;
    } t_result;

    // Queue fill state seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hw/rtl/tga_queue.sv =====
`timescale 1ns / 1ps

module tga_queue #(
    parameter int DEPTH = tga_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tga_pkg::t_result    i_word,
    input  logic                i_pop,
    output tga_pkg::t_result    o_word,
    output tga_pkg::t_q_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tga_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_word         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== hw/rtl/tga_front.sv =====
`timescale 1ns / 1ps

module tga_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    output logic              o_push,
    output tga_pkg::t_result  o_word
);

    localparam logic [1:0] LAST_BYTE_24 = 2'd2;
    localparam logic [1:0] LAST_BYTE_32 = 2'd3;

    tga_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_hdr_cnt, n_hdr_cnt;
    logic [7:0]  r_id_len, n_id_len;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_depth, n_depth;
    logic [7:0]  r_desc, n_desc;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_skip, n_skip;
    logic [31:0] r_pix_left, n_pix_left;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_run, n_run;
    logic [1:0]  r_byte_ph, n_byte_ph;
    logic [23:0] r_pix_bytes, n_pix_bytes;

    tga_pkg::t_phase w_phase;
    logic [4:0]  w_hdr_cnt;
    logic        w_hdr_end;
    logic [31:0] w_area;
    logic        w_depth_ok;
    logic        w_kind_ok;
    logic        w_is_rle;
    logic        w_wide;
    logic        w_pix_done;
    logic        w_run_pix;
    logic [7:0]  w_rep;
    logic [31:0] w_pix_left_nx;
    logic        w_last;
    logic [7:0]  w_cnt_raw;
    logic [7:0]  w_cnt;

    // A start-of-file byte restarts the header parse in the same cycle.
    assign w_phase   = i_first_byte ? tga_pkg::PH_HEADER : r_phase;
    assign w_hdr_cnt = i_first_byte ? 5'd0 : r_hdr_cnt;
    assign w_hdr_end = (w_hdr_cnt == tga_pkg::HB_DESC);

    // Header checks, evaluated on the descriptor byte.
    assign w_area     = {16'd0, r_width} * {16'd0, r_height};
    assign w_depth_ok = r_depth inside {tga_pkg::DEPTH_24, tga_pkg::DEPTH_32};
    assign w_kind_ok  = r_kind inside {tga_pkg::KIND_RAW, tga_pkg::KIND_RLE};
    assign w_is_rle   = (r_kind == tga_pkg::KIND_RLE);
    assign w_wide     = (r_depth == tga_pkg::DEPTH_32);

    // Pixel completion and the pixel count it consumes.
    assign w_pix_done    = w_wide ? (r_byte_ph == LAST_BYTE_32) : (r_byte_ph == LAST_BYTE_24);
    assign w_run_pix     = w_is_rle && r_run;
    assign w_rep         = w_run_pix ? r_pkt_left : 8'd1;
    assign w_pix_left_nx = r_pix_left - {24'd0, w_rep};
    assign w_last        = (w_pix_left_nx == 32'd0);

    // Packet count, clipped to the pixels left in the image.
    assign w_cnt_raw = {1'b0, i_data_byte[6:0]} + 8'd1;
    assign w_cnt     = ({24'd0, w_cnt_raw} > r_pix_left) ? r_pix_left[7:0] : w_cnt_raw;

    // Next-state logic.
    always_comb begin
        logic v_enter;
        v_enter     = 1'b0;
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_id_len    = r_id_len;
        n_kind      = r_kind;
        n_depth     = r_depth;
        n_desc      = r_desc;
        n_width     = r_width;
        n_height    = r_height;
        n_skip      = r_skip;
        n_pix_left  = r_pix_left;
        n_pkt_left  = r_pkt_left;
        n_run       = r_run;
        n_byte_ph   = r_byte_ph;
        n_pix_bytes = r_pix_bytes;
        if (i_accept) begin
            n_phase   = w_phase;
            n_hdr_cnt = w_hdr_cnt;
            case (w_phase)
                tga_pkg::PH_HEADER: begin
                    case (w_hdr_cnt)
                        tga_pkg::HB_ID_LEN: n_id_len = i_data_byte;
                        tga_pkg::HB_KIND:   n_kind = i_data_byte;
                        tga_pkg::HB_W_LO:   n_width[7:0] = i_data_byte;
                        tga_pkg::HB_W_HI:   n_width[15:8] = i_data_byte;
                        tga_pkg::HB_H_LO:   n_height[7:0] = i_data_byte;
                        tga_pkg::HB_H_HI:   n_height[15:8] = i_data_byte;
                        tga_pkg::HB_DEPTH:  n_depth = i_data_byte;
                        tga_pkg::HB_DESC:   n_desc = i_data_byte;
                        default:            n_hdr_cnt = w_hdr_cnt;
                    endcase
                    if (!w_hdr_end) begin
                        n_hdr_cnt = w_hdr_cnt + 5'd1;
                    end else begin
                        n_hdr_cnt = 5'd0;
                        if (!w_depth_ok || !w_kind_ok) begin
                            n_phase = tga_pkg::PH_IDLE;
                        end else begin
                            n_pix_left = w_area;
                            if (w_area == 32'd0) begin
                                n_phase = tga_pkg::PH_IDLE;
                            end else if (r_id_len != 8'd0) begin
                                n_skip  = r_id_len;
                                n_phase = tga_pkg::PH_SKIP;
                            end else begin
                                v_enter = 1'b1;
                            end
                        end
                    end
                end
                tga_pkg::PH_SKIP: begin
                    n_skip = r_skip - 8'd1;
                    if (r_skip == 8'd1) begin
                        v_enter = 1'b1;
                    end
                end
                tga_pkg::PH_PACKET: begin
                    n_run       = i_data_byte[tga_pkg::RUN_BIT];
                    n_pkt_left  = w_cnt;
                    n_byte_ph   = 2'd0;
                    n_pix_bytes = 24'd0;
                    n_phase     = tga_pkg::PH_PIXEL;
                end
                tga_pkg::PH_PIXEL: begin
                    if (!w_pix_done) begin
                        case (r_byte_ph)
                            2'd0:    n_pix_bytes[7:0] = i_data_byte;
                            2'd1:    n_pix_bytes[15:8] = i_data_byte;
                            default: n_pix_bytes[23:16] = i_data_byte;
                        endcase
                        n_byte_ph = r_byte_ph + 2'd1;
                    end else begin
                        n_byte_ph   = 2'd0;
                        n_pix_bytes = 24'd0;
                        n_pix_left  = w_pix_left_nx;
                        if (w_run_pix) begin
                            n_pkt_left = 8'd0;
                            n_phase    = tga_pkg::PH_PACKET;
                        end else if (w_is_rle) begin
                            n_pkt_left = r_pkt_left - 8'd1;
                            if (r_pkt_left == 8'd1) begin
                                n_phase = tga_pkg::PH_PACKET;
                            end
                        end
                        if (w_last) begin
                            n_phase = tga_pkg::PH_IDLE;
                        end
                    end
                end
                default: n_phase = w_phase;
            endcase
            // Start of pixel data.
            if (v_enter) begin
                n_byte_ph   = 2'd0;
                n_pix_bytes = 24'd0;
                n_run       = 1'b0;
                n_pkt_left  = 8'd0;
                n_phase     = w_is_rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
            end
        end
    end

    // Result word and push strobe.
    always_comb begin
        o_push              = 1'b0;
        o_word.red          = 8'd0;
        o_word.green        = 8'd0;
        o_word.blue         = 8'd0;
        o_word.alpha        = 8'd0;
        o_word.repeat_res   = 8'd0;
        o_word.is_last      = 1'b0;
        o_word.status       = tga_pkg::ST_PIXEL;
        o_word.image_width  = r_width;
        o_word.image_height = r_height;
        o_word.top_origin   = r_desc[tga_pkg::ORIGIN_BIT];
        case (w_phase)
            tga_pkg::PH_HEADER: begin
                if (i_accept && w_hdr_end) begin
                    o_word.top_origin = i_data_byte[tga_pkg::ORIGIN_BIT];
                    o_word.is_last    = 1'b1;
                    if (!w_depth_ok) begin
                        o_push        = 1'b1;
                        o_word.status = tga_pkg::ST_BAD_DEPTH;
                    end else if (!w_kind_ok) begin
                        o_push        = 1'b1;
                        o_word.status = tga_pkg::ST_BAD_KIND;
                    end else if (w_area == 32'd0) begin
                        o_push        = 1'b1;
                        o_word.status = tga_pkg::ST_EMPTY;
                    end
                end
            end
            tga_pkg::PH_PIXEL: begin
                if (i_accept && w_pix_done) begin
                    o_push            = 1'b1;
                    o_word.repeat_res = w_rep;
                    o_word.is_last    = w_last;
                    o_word.green      = r_pix_bytes[15:8];
                    o_word.blue       = r_pix_bytes[7:0];
                    if (w_wide) begin
                        o_word.red   = r_pix_bytes[23:16];
                        o_word.alpha = i_data_byte;
                    end else begin
                        o_word.red   = i_data_byte;
                        o_word.alpha = tga_pkg::ALPHA_OPAQUE;
                    end
                end
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tga_pkg::PH_HEADER;
            r_hdr_cnt   <= 5'd0;
            r_id_len    <= 8'd0;
            r_kind      <= 8'd0;
            r_depth     <= 8'd0;
            r_desc      <= 8'd0;
            r_width     <= 16'd0;
            r_height    <= 16'd0;
            r_skip      <= 8'd0;
            r_pix_left  <= 32'd0;
            r_pkt_left  <= 8'd0;
            r_run       <= 1'b0;
            r_byte_ph   <= 2'd0;
            r_pix_bytes <= 24'd0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_id_len    <= n_id_len;
            r_kind      <= n_kind;
            r_depth     <= n_depth;
            r_desc      <= n_desc;
            r_width     <= n_width;
            r_height    <= n_height;
            r_skip      <= n_skip;
            r_pix_left  <= n_pix_left;
            r_pkt_left  <= n_pkt_left;
            r_run       <= n_run;
            r_byte_ph   <= n_byte_ph;
            r_pix_bytes <= n_pix_bytes;
        end
    end

endmodule

// ===== hw/rtl/tga_back.sv =====
`timescale 1ns / 1ps

module tga_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tga_pkg::t_result    i_word,
    input  tga_pkg::t_q_status  i_q_status,
    input  logic                i_out_stall,
    output logic                o_pop,
    output logic                o_out_valid,
    output tga_pkg::t_result    o_word
);

    logic             r_valid, n_valid;
    tga_pkg::t_result r_word;

    // Load the output register from the queue whenever the queue holds a word and the register is empty or being taken.
    assign o_pop = !i_q_status.empty && (!r_valid || !i_out_stall);

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_word      = r_word;

endmodule

// ===== hw/rtl/tga_rle_image_decoder_core.sv =====
// TGA image decoder: raw and run-length types at 24 or 32 bits per pixel.
// Input channel: one file byte per word (i_data_byte, i_first_byte) under
// i_in_valid / o_in_stall. i_first_byte marks header byte 0 of a new file and
// clears an earlier halt. Output channel: one RGBA word with a repeat count,
// last flag, status and the parsed header fields under o_out_valid / i_out_stall.
// Throughput is one byte per cycle while the queue has room; each byte needs
// a single parser step. The parser writes each result to a small queue, and
// the output register loads it from there once the register is empty or
// being taken. A header error gives one word with is_last set, after
// which bytes are dropped until the next first byte.
// When the receiver stalls, the output word holds and the queue fills; the
// block stalls its input only once the queue is full.
// Reset is synchronous and active low; after it the parser waits at header
// byte 0 and both the queue and the output register are empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tga_rle_image_decoder_core #(
    parameter int QUEUE_DEPTH = tga_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [7:0]  o_repeat_res,
    output logic        o_is_last,
    output logic [1:0]  o_status,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic        o_top_origin
);

    tga_pkg::t_q_status q_status;
    tga_pkg::t_result   w_front_word;
    tga_pkg::t_result   w_queue_word;
    tga_pkg::t_result   w_out_word;
    logic               w_accept;
    logic               w_push;
    logic               w_pop;

    // Input words are taken while the queue has room.
    assign o_in_stall = q_status.full;
    assign w_accept   = i_in_valid && !q_status.full;

    tga_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_push       (w_push),
        .o_word       (w_front_word)
    );

    tga_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_word   (w_front_word),
        .i_pop    (w_pop),
        .o_word   (w_queue_word),
        .o_status (q_status)
    );

    tga_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_queue_word),
        .i_q_status  (q_status),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_word      (w_out_word)
    );

    // Output fields.
    assign o_red          = w_out_word.red;
    assign o_green        = w_out_word.green;
    assign o_blue         = w_out_word.blue;
    assign o_alpha        = w_out_word.alpha;
    assign o_repeat_res   = w_out_word.repeat_res;
    assign o_is_last      = w_out_word.is_last;
    assign o_status       = w_out_word.status;
    assign o_image_width  = w_out_word.image_width;
    assign o_image_height = w_out_word.image_height;
    assign o_top_origin   = w_out_word.top_origin;

    // The parser never writes a result into a full queue.
    `TGA_ASSERT_NEVER(a_push_full, w_push && q_status.full, "result written to a full queue")
    // Error words always end the image and carry no repeat count.
    `TGA_ASSERT(a_err_last, o_out_valid && (o_status != tga_pkg::ST_PIXEL) |-> o_is_last && (o_repeat_res == 8'd0), "error word without last flag")
    // Pixel words repeat between 1 and 128 times.
    `TGA_ASSERT(a_pix_rep, o_out_valid && (o_status == tga_pkg::ST_PIXEL) |-> (o_repeat_res != 8'd0) && (o_repeat_res <= 8'd128), "pixel repeat count out of range")
    // A queued word reaches an empty output register on the next edge.
    `TGA_ASSERT(a_queue_drain, !q_status.empty && !o_out_valid |=> o_out_valid, "queued word not moved to output")

endmodule

// ===== tb/tga_rle_image_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module tga_rle_image_decoder_core_tb;
    import tga_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 100;

    // One input word: a file byte and its start-of-file mark.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_first_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [7:0]  o_repeat_res;
    logic        o_is_last;
    logic [1:0]  o_status;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic        o_top_origin;

    tga_rle_image_decoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_repeat_res   (o_repeat_res),
        .o_is_last      (o_is_last),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_top_origin   (o_top_origin)
    );

    // Bytes waiting to be sent and decoded words waiting to arrive.
    t_file_byte pending_bytes[$];
    t_result    expected_pixels[$];

    int send_idle_pct = 34;
    int recv_idle_pct = 71;
    int pushed_cnt = 0;
    int body_room = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    // Decoder state as the testbench expects it to be.
    t_phase      dec_phase = PH_HEADER;
    logic [4:0]  hdr_idx = '0;
    logic [7:0]  id_len = '0;
    logic [7:0]  img_kind = '0;
    logic [7:0]  bpp = '0;
    logic [7:0]  desc_byte = '0;
    logic [15:0] img_w = '0;
    logic [15:0] img_h = '0;
    logic [7:0]  id_skip = '0;
    logic [31:0] px_left = '0;
    logic [7:0]  pkt_left = '0;
    logic        run_pkt = 1'b0;
    logic [1:0]  byte_idx = '0;
    logic [23:0] gathered = '0;

    // Clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Prepares the gatherer for the first pixel or packet of the image.
    function automatic void begin_image_data();
        byte_idx = '0;
        gathered = '0;
        run_pkt = 1'b0;
        pkt_left = '0;
        dec_phase = (img_kind == KIND_RLE) ? PH_PACKET : PH_PIXEL;
    endfunction

    // Advances the expected decoder state by one file byte. Returns 1 when the
    // byte finishes a decoded word, which is then placed in res.
    function automatic bit decode_tga_byte(input logic [7:0] d, input logic first,
                                           output t_result res);
        bit          produced;
        int unsigned comps;
        logic [31:0] cnt;
        logic [31:0] area;

        produced = 1'b0;
        res = '0;
        if (first) begin
            dec_phase = PH_HEADER;
            hdr_idx = '0;
        end
        case (dec_phase)
            PH_HEADER: begin
                case (hdr_idx)
                    HB_ID_LEN: id_len = d;
                    HB_KIND:   img_kind = d;
                    HB_W_LO:   img_w[7:0] = d;
                    HB_W_HI:   img_w[15:8] = d;
                    HB_H_LO:   img_h[7:0] = d;
                    HB_H_HI:   img_h[15:8] = d;
                    HB_DEPTH:  bpp = d;
                    HB_DESC:   desc_byte = d;
                    default: ;
                endcase
                if (hdr_idx != HB_DESC) begin
                    hdr_idx = hdr_idx + 5'd1;
                end else begin
                    // Header complete: depth is checked before type, then size.
                    hdr_idx = '0;
                    area = {16'd0, img_w} * {16'd0, img_h};
                    if (bpp != DEPTH_24 && bpp != DEPTH_32) begin
                        produced = 1'b1;
                        res.status = ST_BAD_DEPTH;
                    end else if (img_kind != KIND_RAW && img_kind != KIND_RLE) begin
                        produced = 1'b1;
                        res.status = ST_BAD_KIND;
                    end else begin
                        px_left = area;
                        if (area == 0) begin
                            produced = 1'b1;
                            res.status = ST_EMPTY;
                        end else if (id_len != 0) begin
                            id_skip = id_len;
                            dec_phase = PH_SKIP;
                        end else begin
                            begin_image_data();
                        end
                    end
                    if (produced) begin
                        res.is_last = 1'b1;
                        dec_phase = PH_IDLE;
                    end
                end
            end
            PH_SKIP: begin
                id_skip = id_skip - 8'd1;
                if (id_skip == 0) begin
                    begin_image_data();
                end
            end
            PH_PACKET: begin
                // Packet counts never reach past the end of the image.
                run_pkt = d[RUN_BIT];
                cnt = {25'd0, d[6:0]} + 32'd1;
                if (cnt > px_left) begin
                    cnt = px_left;
                end
                pkt_left = cnt[7:0];
                byte_idx = '0;
                gathered = '0;
                dec_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                comps = (bpp == DEPTH_32) ? 4 : 3;
                if (byte_idx + 1 < comps) begin
                    gathered = gathered | (24'(d) << (8 * byte_idx));
                    byte_idx = byte_idx + 2'd1;
                end else begin
                    byte_idx = '0;
                    if (img_kind == KIND_RLE && run_pkt) begin
                        res.repeat_res = pkt_left;
                        px_left = px_left - {24'd0, pkt_left};
                        pkt_left = '0;
                        dec_phase = PH_PACKET;
                    end else begin
                        res.repeat_res = 8'd1;
                        px_left = px_left - 32'd1;
                        if (img_kind == KIND_RLE) begin
                            pkt_left = pkt_left - 8'd1;
                            if (pkt_left == 0) begin
                                dec_phase = PH_PACKET;
                            end
                        end
                    end
                    if (px_left == 0) begin
                        res.is_last = 1'b1;
                        dec_phase = PH_IDLE;
                    end
                    // The file holds blue first; swap into RGBA order.
                    if (comps == 4) begin
                        res.red = gathered[23:16];
                        res.green = gathered[15:8];
                        res.blue = gathered[7:0];
                        res.alpha = d;
                    end else begin
                        res.red = d;
                        res.green = gathered[15:8];
                        res.blue = gathered[7:0];
                        res.alpha = ALPHA_OPAQUE;
                    end
                    res.status = ST_PIXEL;
                    gathered = '0;
                    produced = 1'b1;
                end
            end
            default: ;
        endcase
        res.image_width = img_w;
        res.image_height = img_h;
        res.top_origin = desc_byte[ORIGIN_BIT];
        return produced;
    endfunction

    // Prints one mismatch line, up to a limit, and counts every one.
    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic push_byte(input logic [7:0] d, input logic first);
        pending_bytes.push_back('{data: d, first: first});
        pushed_cnt++;
    endtask

    // Data bytes after the header; a file cut short stops when the room runs out.
    task automatic push_data(input logic [7:0] d);
        if (body_room > 0) begin
            push_byte(d, 1'b0);
            body_room--;
        end
    endtask

    task automatic push_header(input logic mark, input logic [7:0] kind,
                               input logic [7:0] depth, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] idl,
                               input logic [7:0] desc);
        logic [7:0] b;

        for (int i = 0; i < 18; i++) begin
            case (5'(i))
                HB_ID_LEN: b = idl;
                HB_KIND:   b = kind;
                HB_W_LO:   b = w[7:0];
                HB_W_HI:   b = w[15:8];
                HB_H_LO:   b = h[7:0];
                HB_H_HI:   b = h[15:8];
                HB_DEPTH:  b = depth;
                HB_DESC:   b = desc;
                default:   b = 8'($urandom);
            endcase
            push_byte(b, (i == 0) ? mark : 1'b0);
        end
        for (int i = 0; i < idl; i++) begin
            push_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic push_pixel(input logic [7:0] depth);
        repeat ((depth == DEPTH_32) ? 4 : 3) push_data(8'($urandom));
    endtask

    // Pixel data for npix pixels. Packet counts may run past the end of the
    // image, in which case the decoder clips them.
    task automatic push_body(input logic [7:0] kind, input logic [7:0] depth,
                             input int unsigned npix, input int run_pct);
        int unsigned left;
        int unsigned cnt;
        int unsigned used;
        logic        run;

        left = npix;
        if (kind == KIND_RAW) begin
            repeat (npix) push_pixel(depth);
        end else begin
            while (left > 0) begin
                if ($urandom_range(0, 99) < run_pct) begin
                    run = 1'b1;
                    cnt = $urandom_range(1, 128);
                end else begin
                    run = 1'($urandom_range(0, 1));
                    cnt = $urandom_range(1, 4);
                end
                used = (cnt > left) ? left : cnt;
                push_data({run, 7'(cnt - 1)});
                if (run) begin
                    push_pixel(depth);
                end else begin
                    repeat (used) push_pixel(depth);
                end
                left -= used;
            end
        end
    endtask

    // One random file: mostly well formed, some cut short, some with header
    // errors, some empty, and a little noise.
    task automatic random_file();
        int          sel;
        int          run_pct;
        logic [7:0]  kind;
        logic [7:0]  depth;
        logic [7:0]  idl;
        logic [15:0] w;
        logic [15:0] h;

        sel = $urandom_range(0, 99);
        kind = $urandom_range(0, 1) ? KIND_RLE : KIND_RAW;
        depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 4));
        run_pct = 20;
        idl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 5)) : 8'd0;
        if ($urandom_range(0, 39) == 0) begin
            idl = 8'($urandom_range(200, 255));
        end
        body_room = 1 << 30;
        if (sel < 60) begin
            // Now and then a wide image made mostly of long runs.
            if (kind == KIND_RLE && $urandom_range(0, 7) == 0) begin
                w = 16'($urandom_range(200, 700));
                h = 16'($urandom_range(1, 3));
                run_pct = 95;
            end
        end else if (sel < 70) begin
            body_room = $urandom_range(0, 10);
        end else if (sel < 78) begin
            do depth = 8'($urandom); while (depth == DEPTH_24 || depth == DEPTH_32);
            kind = 8'($urandom);
            w = 16'($urandom);
            h = 16'($urandom);
        end else if (sel < 86) begin
            do kind = 8'($urandom); while (kind == KIND_RAW || kind == KIND_RLE);
            w = 16'($urandom);
            h = 16'($urandom);
        end else if (sel < 94) begin
            if ($urandom_range(0, 1)) begin
                w = 16'd0;
                h = 16'($urandom);
            end else begin
                w = 16'($urandom);
                h = 16'd0;
            end
        end else begin
            // Noise, sometimes with a restart that breaks off inside the header.
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
            return;
        end
        push_header(1'b1, kind, depth, w, h, idl, 8'($urandom));
        if (sel < 70) begin
            push_body(kind, depth, int'(w) * int'(h), run_pct);
        end
        body_room = 1 << 30;
        repeat ($urandom_range(0, 2)) push_data(8'($urandom));
    endtask

    // Holds the sender back until every byte is taken and every word is in.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_in_valid || expected_pixels.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: presents the next file byte, holding it while stalled.
    always @(posedge i_clk) begin
        t_file_byte next_byte;

        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_byte = pending_bytes.pop_front();
                i_in_valid <= 1'b1;
                i_data_byte <= next_byte.data;
                i_first_byte <= next_byte.first;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted byte, checks each accepted word, and
    // stalls the output at random.
    always @(posedge i_clk) begin
        t_result pred;
        t_result want;

        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (decode_tga_byte(i_data_byte, i_first_byte, pred)) begin
                    expected_pixels.push_back(pred);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("output word arrived with none expected");
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", o_red, want.red);
                    check_field("green", o_green, want.green);
                    check_field("blue", o_blue, want.blue);
                    check_field("alpha", o_alpha, want.alpha);
                    check_field("repeat_res", o_repeat_res, want.repeat_res);
                    check_field("is_last", o_is_last, want.is_last);
                    check_field("status", o_status, want.status);
                    check_field("image_width", o_image_width, want.image_width);
                    check_field("image_height", o_image_height, want.image_height);
                    check_field("top_origin", o_top_origin, want.top_origin);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Ends a hung run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        body_room = 1 << 30;

        // A file right after reset, without the start mark, then a stray byte.
        push_header(1'b0, KIND_RAW, DEPTH_24, 16'd1, 16'd2, 8'd0, 8'h20);
        repeat (3) push_data(8'h00);
        repeat (3) push_data(8'hFF);
        push_data(8'hAA);

        // Bad depth and bad type together: depth is reported. Bytes after are dropped.
        push_header(1'b1, 8'd1, 8'd8, 16'hFFFF, 16'hFFFF, 8'd0, 8'hFF);
        push_data(8'h55);

        // A restart that breaks off in the header of the next file.
        push_byte(8'd3, 1'b1);
        push_byte(8'd0, 1'b0);
        push_byte(KIND_RAW, 1'b0);

        // Run-length at 32 bits with an ID field; a run of 128 is clipped to
        // what remains, then trailing bytes are ignored.
        push_header(1'b1, KIND_RLE, DEPTH_32, 16'd3, 16'd1, 8'd2, 8'h00);
        push_data(8'h00);
        push_pixel(DEPTH_32);
        push_data(8'hFF);
        push_pixel(DEPTH_32);
        push_data(8'h80);
        push_data(8'h7F);

        // A raw packet of 128 in a one-pixel image.
        push_header(1'b1, KIND_RLE, DEPTH_24, 16'd1, 16'd1, 8'd0, 8'hDF);
        push_data(8'h7F);
        push_pixel(DEPTH_24);

        while (pushed_cnt < 250) random_file();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        send_idle_pct = 71;
        recv_idle_pct = 34;
        while (pushed_cnt < 490) random_file();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pushed_cnt < 720) random_file();
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
